// ===== sv/aes_pkg.sv =====
// Package with AES-128 types, constants and round functions.
`default_nettype none
package aes_pkg;
	localparam int ROUNDS = 10;
	localparam int KEY_IDX_W = 1;
	localparam logic [KEY_IDX_W-1:0] REG_KEY_HIGH = 1'd0;
	localparam logic [KEY_IDX_W-1:0] REG_KEY_LOW = 1'd1;
	localparam logic [7:0] GF_REDUCE = 8'h1b;

	typedef logic [127:0] block_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] RCON [ROUNDS] = '{
		8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
	};

	function automatic logic [7:0] get_byte(input block_t b, input int n);
		get_byte = b[127-8*n -: 8];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] v);
		xtime = {v[6:0], 1'b0} ^ (v[7] ? GF_REDUCE : 8'h00);
	endfunction

	function automatic block_t next_key(input block_t k, input logic [7:0] rc);
		logic [31:0] t;
		logic [31:0] w0, w1, w2, w3;
		w0 = k[127:96];
		w1 = k[95:64];
		w2 = k[63:32];
		w3 = k[31:0];
		t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
		w0 = w0 ^ t;
		w1 = w1 ^ w0;
		w2 = w2 ^ w1;
		w3 = w3 ^ w2;
		next_key = {w0, w1, w2, w3};
	endfunction

	function automatic block_t enc_round(input block_t s, input block_t rk, input logic last);
		block_t o;
		logic [7:0] a0, a1, a2, a3, all;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				o[127-8*(r+4*c) -: 8] = SBOX[get_byte(s, r + 4*((c + r) % 4))];
			end
		end
		if (!last) begin
			for (int c = 0; c < 4; c++) begin
				a0 = get_byte(o, 4*c);
				a1 = get_byte(o, 4*c+1);
				a2 = get_byte(o, 4*c+2);
				a3 = get_byte(o, 4*c+3);
				all = a0 ^ a1 ^ a2 ^ a3;
				o[127-32*c -: 32] = {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
					a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
			end
		end
		enc_round = o ^ rk;
	endfunction
endpackage
`default_nettype wire

// ===== sv/aes_round_stage.sv =====
// One pipeline stage: an AES round and the matching key schedule step.
`default_nettype none
module aes_round_stage (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic valid_in,
	input  wire aes_pkg::block_t state_in,
	input  wire aes_pkg::block_t key_in,
	input  wire logic [7:0] rcon,
	input  wire logic last,
	output logic valid_out,
	output aes_pkg::block_t state_out,
	output aes_pkg::block_t key_out
);
	aes_pkg::block_t rk;
	assign rk = aes_pkg::next_key(key_in, rcon);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			state_out <= aes_pkg::enc_round(state_in, rk, last);
			key_out <= rk;
		end
	end
endmodule
`default_nettype wire

// ===== sv/aes128_block_encrypt_unit.sv =====
// Top level of the pipelined AES-128 block encryption unit.
// Throughput: one request per cycle while the output is not stalled; stages are the initial key add and ten rounds.
// A stall at the output freezes the whole pipeline; nothing is lost or repeated.
// Reset clears the stage valid bits and the key registers to zero.
`default_nettype none
module aes128_block_encrypt_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [63:0] plaintext_high,
	input  wire logic [63:0] plaintext_low,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [63:0] ciphertext_high,
	output logic [63:0] ciphertext_low,
	input  wire logic cfg_we,
	input  wire logic [aes_pkg::KEY_IDX_W-1:0] cfg_index,
	input  wire logic [63:0] cfg_data
);
	logic [63:0] key_high_q, key_low_q;
	logic en;
	logic valid_s0;
	aes_pkg::block_t state_s0;
	aes_pkg::block_t key_s0;
	logic v [0:aes_pkg::ROUNDS];
	aes_pkg::block_t st [0:aes_pkg::ROUNDS];
	aes_pkg::block_t kk [0:aes_pkg::ROUNDS];

	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				aes_pkg::REG_KEY_HIGH: key_high_q <= cfg_data;
				aes_pkg::REG_KEY_LOW: key_low_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (en) begin
			valid_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			state_s0 <= {plaintext_high, plaintext_low} ^ {key_high_q, key_low_q};
			key_s0 <= {key_high_q, key_low_q};
		end
	end

	assign v[0] = valid_s0;
	assign st[0] = state_s0;
	assign kk[0] = key_s0;

	for (genvar i = 1; i <= aes_pkg::ROUNDS; i++) begin : g_round
		aes_round_stage u_round (
			.clk(clk), .arst_n(arst_n), .en(en),
			.valid_in(v[i-1]), .state_in(st[i-1]), .key_in(kk[i-1]),
			.rcon(aes_pkg::RCON[i-1]), .last(i == aes_pkg::ROUNDS),
			.valid_out(v[i]), .state_out(st[i]), .key_out(kk[i])
		);
	end

	assign out_valid = v[aes_pkg::ROUNDS];
	assign ciphertext_high = st[aes_pkg::ROUNDS][127:64];
	assign ciphertext_low = st[aes_pkg::ROUNDS][63:0];
endmodule
`default_nettype wire

// ===== sv/aes_checker.sv =====
// Port-level checker for the AES-128 encryption unit, bound to the top level.
`default_nettype none
module aes_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [63:0] ciphertext_high,
	input wire logic [63:0] ciphertext_low
);
	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall)) else $error("input stalled without output stall");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(ciphertext_high)
		&& $stable(ciphertext_low))) else $error("stalled result changed");
	a_no_result_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid) else $error("result right after reset");
	a_free_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall) else $error("stall without a blocked result");
endmodule

bind aes128_block_encrypt_unit aes_checker u_aes_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall),
	.ciphertext_high(ciphertext_high), .ciphertext_low(ciphertext_low)
);
`default_nettype wire
